// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Clocked assertion that also holds through reset.
`define ASSERT_CLK(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/mpfw_pkg.sv =====
// Types and constants of the mono page frame buffer writer.
package mpfw_pkg;

   localparam int PANEL_WIDTH  = 128;
   localparam int PANEL_HEIGHT = 64;
   localparam int STORE_BYTES  = PANEL_WIDTH * PANEL_HEIGHT / 8;
   localparam int STORE_AW     = $clog2(STORE_BYTES);

   localparam int COLUMN_W   = 7;
   localparam int ROW_W      = 6;
   localparam int PIXEL_W    = 16;
   localparam int THRESH_W   = 13;
   localparam int LUMA_W     = 13;
   localparam int INDEX_W    = 10;
   localparam int BYTE_W     = 8;
   localparam int BIT_SEL_W  = 3;
   localparam int IDX_FULL_W = 12;

   localparam logic [IDX_FULL_W-1:0] WIDTH_LIMIT  = IDX_FULL_W'(PANEL_WIDTH);
   localparam logic [IDX_FULL_W-1:0] HEIGHT_LIMIT = IDX_FULL_W'(PANEL_HEIGHT);
   localparam logic [IDX_FULL_W-1:0] STORE_LIMIT  = IDX_FULL_W'(STORE_BYTES);
   localparam logic [STORE_AW-1:0]   STORE_LAST   = STORE_AW'(STORE_BYTES - 1);

   localparam logic [THRESH_W-1:0] THRESHOLD_RESET = THRESH_W'(1200);

   localparam logic [6:0] LUMA_R_WEIGHT = 7'd38;
   localparam logic [6:0] LUMA_G_WEIGHT = 7'd75;
   localparam logic [6:0] LUMA_B_WEIGHT = 7'd15;

   typedef enum logic {
      MODE_WRITE = 1'b0,
      MODE_READ  = 1'b1
   } mode_type;

   // Item held between the input side and the result register.
   typedef struct packed {
      mode_type                mode;
      logic                    in_frame;
      logic [IDX_FULL_W-1:0]   idx;
      logic [BIT_SEL_W-1:0]    bit_sel;
      logic [PIXEL_W-1:0]      pixel;
      logic                    flush_last;
      logic                    bypass;
      logic [BYTE_W-1:0]       bypass_data;
   } stage_type;

   typedef struct packed {
      logic [INDEX_W-1:0] byte_index;
      logic [BYTE_W-1:0]  byte_value;
      logic               frame_ready;
   } rsp_word_type;

endpackage

// ===== hw/rtl/mpfw_if.sv =====
// Valid/ready channel interfaces for pixel requests and byte responses.
interface mpfw_req_if
   import mpfw_pkg::*;
();
   logic                valid;
   logic                ready;
   logic                mode;
   logic [COLUMN_W-1:0] column;
   logic [ROW_W-1:0]    row;
   logic [PIXEL_W-1:0]  pixel;
   logic                flush_last;

   modport source (output valid, mode, column, row, pixel, flush_last, input ready);
   modport sink   (input valid, mode, column, row, pixel, flush_last, output ready);
endinterface

interface mpfw_rsp_if
   import mpfw_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] byte_index;
   logic [BYTE_W-1:0]  byte_value;
   logic               frame_ready;

   modport source (output valid, byte_index, byte_value, frame_ready, input ready);
   modport sink   (input valid, byte_index, byte_value, frame_ready, output ready);
endinterface

// ===== hw/rtl/mpfw_ram.sv =====
// Generic single-write, single-read RAM with registered read-first output.
module mpfw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

// ===== hw/rtl/mpfw_byte_update.sv =====
// RGB565 luma threshold and single-bit update of one frame buffer byte.
module mpfw_byte_update
   import mpfw_pkg::*;
(
   input  logic [PIXEL_W-1:0]   pixel,
   input  logic [THRESH_W-1:0]  threshold,
   input  logic [BIT_SEL_W-1:0] bit_sel,
   input  logic [BYTE_W-1:0]    old_byte,
   output logic [BYTE_W-1:0]    new_byte
);
   logic [LUMA_W-1:0] luma;
   logic [BYTE_W-1:0] mask;
   logic              lit;

   assign luma = LUMA_W'(pixel[15:11]) * LUMA_W'(LUMA_R_WEIGHT)
               + LUMA_W'(pixel[10:5])  * LUMA_W'(LUMA_G_WEIGHT)
               + LUMA_W'(pixel[4:0])   * LUMA_W'(LUMA_B_WEIGHT);
   assign lit  = luma > threshold;
   assign mask = BYTE_W'(1) << bit_sel;

   assign new_byte = lit ? (old_byte | mask) : (old_byte & ~mask);
endmodule

// ===== hw/rtl/mono_page_framebuffer_writer.sv =====
// Takes RGB565 pixels one word per cycle when not stalled, thresholds their
// weighted luma (r*38 + g*75 + b*15 against csr_wr_data's threshold) and
// sets or clears one bit of a page-packed mono frame buffer, returning the
// updated byte and its index; read words return a stored byte. The block
// sustains one word per cycle while the response side takes each byte:
// acceptance issues the frame buffer read and loads the stage register,
// and when that stage advances the byte is written back and the response
// register loaded; back-to-back hits on one byte are bypassed. After reset
// it clears the 1024-byte buffer, one byte a cycle, with req_chan.ready low.
module mono_page_framebuffer_writer
   import mpfw_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   mpfw_req_if.sink            req_chan,
   mpfw_rsp_if.source          rsp_chan,
   input  logic                csr_wr_en,
   input  logic [THRESH_W-1:0] csr_wr_data
);
   logic [THRESH_W-1:0] threshold_ff;
   logic                clear_active_ff;
   logic [STORE_AW-1:0] clear_addr_ff;
   logic                s1_valid_ff, s1_valid_in;
   stage_type           s1_ff, s1_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_word_type        rsp_word_ff, rsp_word_in;

   logic [IDX_FULL_W-1:0] req_idx;
   logic                  req_in_frame;
   logic                  accept;
   logic                  s1_advance;
   logic                  s1_wr_en;
   logic [BYTE_W-1:0]     ram_rd_data;
   logic [BYTE_W-1:0]     old_byte;
   logic [BYTE_W-1:0]     new_byte;
   logic                  ram_wr_en;
   logic [STORE_AW-1:0]   ram_wr_addr;
   logic [BYTE_W-1:0]     ram_wr_data;

   assign req_idx = IDX_FULL_W'(req_chan.column)
                  + IDX_FULL_W'(req_chan.row >> 3) * WIDTH_LIMIT;
   assign req_in_frame = (IDX_FULL_W'(req_chan.column) < WIDTH_LIMIT)
                      && (IDX_FULL_W'(req_chan.row) < HEIGHT_LIMIT)
                      && (req_idx < STORE_LIMIT);

   assign s1_advance     = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !clear_active_ff && (!s1_valid_ff || s1_advance);
   assign accept         = req_chan.valid && req_chan.ready;
   assign s1_wr_en       = s1_valid_ff && s1_advance && (s1_ff.mode == MODE_WRITE)
                        && s1_ff.in_frame;

   // Take the byte written back as this word was accepted when the word hits it.
   assign old_byte = s1_ff.bypass ? s1_ff.bypass_data : ram_rd_data;

   mpfw_byte_update u_byte_update (
      .pixel     (s1_ff.pixel),
      .threshold (threshold_ff),
      .bit_sel   (s1_ff.bit_sel),
      .old_byte  (old_byte),
      .new_byte  (new_byte)
   );

   always_comb begin
      if (clear_active_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clear_addr_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = s1_wr_en;
         ram_wr_addr = s1_ff.idx[STORE_AW-1:0];
         ram_wr_data = new_byte;
      end
   end

   mpfw_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (STORE_BYTES)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (req_idx[STORE_AW-1:0]),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      s1_in             = s1_ff;
      s1_valid_in       = s1_valid_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_word_in       = rsp_word_ff;

      if (s1_advance) begin
         rsp_valid_in = s1_valid_ff;
         s1_valid_in  = 1'b0;
         rsp_word_in.byte_index = s1_ff.idx[INDEX_W-1:0];
         if (!s1_ff.in_frame) begin
            rsp_word_in.byte_value = '0;
         end else if (s1_ff.mode == MODE_WRITE) begin
            rsp_word_in.byte_value = new_byte;
         end else begin
            rsp_word_in.byte_value = old_byte;
         end
         rsp_word_in.frame_ready = (s1_ff.mode == MODE_WRITE) && s1_ff.flush_last;
      end

      if (accept) begin
         s1_valid_in       = 1'b1;
         s1_in.mode        = mode_type'(req_chan.mode);
         s1_in.in_frame    = req_in_frame;
         s1_in.idx         = req_idx;
         s1_in.bit_sel     = req_chan.row[BIT_SEL_W-1:0];
         s1_in.pixel       = req_chan.pixel;
         s1_in.flush_last  = req_chan.flush_last;
         s1_in.bypass      = s1_wr_en && (s1_ff.idx == req_idx);
         s1_in.bypass_data = new_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff    <= THRESHOLD_RESET;
         clear_active_ff <= 1'b1;
         clear_addr_ff   <= '0;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            threshold_ff <= csr_wr_data;
         end
         if (clear_active_ff) begin
            clear_addr_ff <= clear_addr_ff + 1'b1;
            if (clear_addr_ff == STORE_LAST) begin
               clear_active_ff <= 1'b0;
            end
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff       <= s1_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.byte_index  = rsp_word_ff.byte_index;
   assign rsp_chan.byte_value  = rsp_word_ff.byte_value;
   assign rsp_chan.frame_ready = rsp_word_ff.frame_ready;
endmodule

// ===== hw/rtl/mpfw_checker.sv =====
// Port-level checker for the frame buffer writer, bound to the top level.
`include "assert_macros.svh"

module mpfw_checker
   import mpfw_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [INDEX_W-1:0] rsp_byte_index,
   input logic [BYTE_W-1:0]  rsp_byte_value,
   input logic               rsp_frame_ready
);
   logic [1:0] outstanding_ff;

   // Count words taken in but not yet answered.
   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_ff + 2'(req_valid && req_ready)
                         - 2'(rsp_valid && rsp_ready);
      end
   end

   `ASSERT_CLK(a_clear_after_reset, clock, $past(reset) |-> !req_ready)
   `ASSERT_CLK_RST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_byte_index) && $stable(rsp_byte_value) && $stable(rsp_frame_ready))
   `ASSERT_CLK_RST(a_rsp_has_word, clock, reset, rsp_valid |-> outstanding_ff != 2'd0)
   `ASSERT_CLK_RST(a_depth_bound, clock, reset, outstanding_ff != 2'd3)
endmodule

bind mono_page_framebuffer_writer mpfw_checker u_mpfw_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_byte_index  (rsp_chan.byte_index),
   .rsp_byte_value  (rsp_chan.byte_value),
   .rsp_frame_ready (rsp_chan.frame_ready)
);

// ===== verif/mpfw_byte_checker.sv =====
// Watches the pixel and byte channels, predicts each byte from a frame copy and compares.
`timescale 1ns / 1ps

module mpfw_byte_checker
   import mpfw_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   mpfw_req_if                 req_mon,
   mpfw_rsp_if                 rsp_mon,
   input  logic                csr_wr_en,
   input  logic [THRESH_W-1:0] csr_wr_data,
   output int unsigned         mismatch_count,
   output int unsigned         outstanding
);

   logic [BYTE_W-1:0]   frame_copy [STORE_BYTES];
   logic [THRESH_W-1:0] luma_limit;
   rsp_word_type        expected_bytes [$];
   rsp_word_type        got_word;
   rsp_word_type        want_word;

   initial begin
      mismatch_count = 0;
      outstanding    = 0;
   end

   function automatic int unsigned pixel_luma(logic [PIXEL_W-1:0] px);
      return int'(px[15:11]) * 38 + int'(px[10:5]) * 75 + int'(px[4:0]) * 15;
   endfunction

   // Update the frame copy for one word and return the byte the block should send.
   function automatic rsp_word_type apply_pixel_word(mode_type mode, logic [COLUMN_W-1:0] col,
                                                     logic [ROW_W-1:0] row,
                                                     logic [PIXEL_W-1:0] px, logic last);
      int unsigned       addr;
      logic              in_frame;
      logic [BYTE_W-1:0] bit_mask;
      rsp_word_type      w;
      addr     = int'(col) + int'(row >> 3) * PANEL_WIDTH;
      in_frame = (int'(col) < PANEL_WIDTH) && (int'(row) < PANEL_HEIGHT) && (addr < STORE_BYTES);
      bit_mask = BYTE_W'(1) << row[2:0];
      w.byte_index  = INDEX_W'(addr);
      w.byte_value  = '0;
      w.frame_ready = 1'b0;
      if (mode == MODE_WRITE) begin
         if (in_frame) begin
            if (pixel_luma(px) > int'(luma_limit))
               frame_copy[addr] = frame_copy[addr] | bit_mask;
            else
               frame_copy[addr] = frame_copy[addr] & ~bit_mask;
            w.byte_value = frame_copy[addr];
         end
         w.frame_ready = last;
      end else if (in_frame) begin
         w.byte_value = frame_copy[addr];
      end
      return w;
   endfunction

   function automatic void note_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t mismatch (%s): expected index %0d value %02h ready %0b, got index %0d value %02h ready %0b",
                  $time, what, want_word.byte_index, want_word.byte_value, want_word.frame_ready,
                  got_word.byte_index, got_word.byte_value, got_word.frame_ready);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STORE_BYTES; i++) frame_copy[i] = '0;
         luma_limit = THRESHOLD_RESET;
         expected_bytes.delete();
      end else begin
         if (csr_wr_en) luma_limit = csr_wr_data;
         // Retire the response before taking the new pixel: a word can never
         // come back in the cycle it was accepted.
         if (rsp_mon.valid && rsp_mon.ready) begin
            got_word.byte_index  = rsp_mon.byte_index;
            got_word.byte_value  = rsp_mon.byte_value;
            got_word.frame_ready = rsp_mon.frame_ready;
            if (expected_bytes.size() == 0) begin
               want_word = '0;
               note_mismatch("no word expected");
            end else begin
               want_word = expected_bytes.pop_front();
               if (got_word.byte_index !== want_word.byte_index)
                  note_mismatch("byte_index");
               else if (got_word.byte_value !== want_word.byte_value)
                  note_mismatch("byte_value");
               else if (got_word.frame_ready !== want_word.frame_ready)
                  note_mismatch("frame_ready");
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_bytes.push_back(apply_pixel_word(mode_type'(req_mon.mode), req_mon.column,
                                                      req_mon.row, req_mon.pixel,
                                                      req_mon.flush_last));
      end
      outstanding = expected_bytes.size();
   end

endmodule

// ===== verif/mono_page_framebuffer_writer_test.sv =====
// Drives pixel and read words into the frame buffer writer and gives the verdict.
`timescale 1ns / 1ps

module mono_page_framebuffer_writer_test;
   import mpfw_pkg::*;

   localparam int unsigned CYCLE_LIMIT     = 300000;
   localparam int unsigned HOLD_OFF_CYCLES = 200;
   localparam int unsigned PHASE_WORDS     = 250;

   logic                clock;
   logic                reset;
   logic                csr_wr_en;
   logic [THRESH_W-1:0] csr_wr_data;
   int unsigned         mismatch_count;
   int unsigned         outstanding;
   int unsigned         cycle_count;
   int unsigned         req_idle_pct;
   int unsigned         rsp_stall_pct;
   int unsigned         holdoffs_asked;
   int unsigned         holdoffs_done;
   int unsigned         hold_left;
   logic [COLUMN_W-1:0] hot_column;
   logic [ROW_W-1:0]    hot_row;

   mpfw_req_if pix_req ();
   mpfw_rsp_if byte_rsp ();

   mono_page_framebuffer_writer dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (pix_req),
      .rsp_chan    (byte_rsp),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   mpfw_byte_checker byte_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (pix_req),
      .rsp_mon        (byte_rsp),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Response side: random stalls, plus a long hold-off whenever one is asked.
   always @(negedge clock) begin
      if (hold_left != 0) begin
         byte_rsp.ready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (holdoffs_done != holdoffs_asked) begin
         holdoffs_done  = holdoffs_done + 1;
         hold_left      = HOLD_OFF_CYCLES;
         byte_rsp.ready <= 1'b0;
      end else begin
         byte_rsp.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // Offer one word from a falling edge; return at the falling edge after acceptance.
   task automatic send_word(mode_type mode, logic [COLUMN_W-1:0] col, logic [ROW_W-1:0] row,
                            logic [PIXEL_W-1:0] px, logic last);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         pix_req.valid <= 1'b0;
         @(negedge clock);
      end
      pix_req.valid      <= 1'b1;
      pix_req.mode       <= mode;
      pix_req.column     <= col;
      pix_req.row        <= row;
      pix_req.pixel      <= px;
      pix_req.flush_last <= last;
      do @(posedge clock); while (!pix_req.ready);
      @(negedge clock);
   endtask

   // Half the words hit the byte of the previous one, so read-modify-write
   // hazards and back-to-back reads of a fresh byte come up often.
   task automatic send_random_word();
      mode_type            mode;
      logic [COLUMN_W-1:0] col;
      logic [ROW_W-1:0]    row;
      mode = ($urandom_range(0, 3) == 0) ? MODE_READ : MODE_WRITE;
      if ($urandom_range(0, 1) == 0) begin
         col = hot_column;
         row = {hot_row[5:3], 3'($urandom_range(0, 7))};
      end else begin
         col = COLUMN_W'($urandom_range(0, 127));
         row = ROW_W'($urandom_range(0, 63));
      end
      hot_column = col;
      hot_row    = row;
      send_word(mode, col, row, PIXEL_W'($urandom_range(0, 65535)), ($urandom_range(0, 15) == 0));
   endtask

   task automatic write_threshold(logic [THRESH_W-1:0] value);
      pix_req.valid <= 1'b0;
      wait (outstanding == 0);
      repeat (4) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct,
                            logic [THRESH_W-1:0] value, logic with_hold_off);
      write_threshold(value);
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      if (with_hold_off) holdoffs_asked = holdoffs_asked + 1;
      repeat (PHASE_WORDS) send_random_word();
   endtask

   initial begin
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      pix_req.valid      = 1'b0;
      pix_req.mode       = MODE_WRITE;
      pix_req.column     = '0;
      pix_req.row        = '0;
      pix_req.pixel      = '0;
      pix_req.flush_last = 1'b0;
      byte_rsp.ready     = 1'b0;
      cycle_count        = 0;
      req_idle_pct       = 0;
      rsp_stall_pct      = 0;
      holdoffs_asked     = 0;
      holdoffs_done      = 0;
      hold_left          = 0;
      hot_column         = '0;
      hot_row            = '0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Directed words at the reset threshold; the block clears its buffer first.
      send_word(MODE_WRITE, 7'd0, 6'd0, 16'hFFFF, 1'b0);
      send_word(MODE_WRITE, 7'd127, 6'd63, 16'h0000, 1'b0);
      send_word(MODE_WRITE, 7'd127, 6'd63, 16'hFFFF, 1'b1);
      // Fill one byte bit by bit, just above the threshold.
      for (int r = 0; r < 8; r++) send_word(MODE_WRITE, 7'd5, ROW_W'(r), 16'h11E0, 1'b0);
      // Luma equal to the threshold clears the bit.
      send_word(MODE_WRITE, 7'd5, 6'd3, 16'h0200, 1'b0);
      send_word(MODE_READ, 7'd5, 6'd0, 16'hFFFF, 1'b1);
      send_word(MODE_READ, 7'd127, 6'd63, 16'h0000, 1'b0);
      send_word(MODE_READ, 7'd64, 6'd32, 16'h0000, 1'b0);
      send_word(MODE_WRITE, 7'd64, 6'd32, 16'hF800, 1'b0);
      send_word(MODE_WRITE, 7'd64, 6'd33, 16'h07E0, 1'b0);
      send_word(MODE_WRITE, 7'd64, 6'd34, 16'h001F, 1'b1);
      send_word(MODE_READ, 7'd64, 6'd39, 16'h0000, 1'b0);

      run_phase(0, 0, THRESH_W'(0), 1'b0);
      run_phase(86, 0, THRESH_W'(6368), 1'b0);
      run_phase(0, 86, THRESH_W'(4095), 1'b0);
      run_phase(25, 25, THRESH_W'($urandom_range(0, 6368)), 1'b0);
      // Hold the response side off while words keep coming, to back the block up.
      run_phase(0, 0, THRESH_W'($urandom_range(0, 6368)), 1'b1);
      run_phase(25, 25, THRESH_W'(1200), 1'b0);

      pix_req.valid <= 1'b0;
      wait (outstanding == 0);
      repeat (8) @(negedge clock);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ===== mono_page_framebuffer_writer.f =====
+incdir+hw/rtl
hw/rtl/mpfw_pkg.sv
hw/rtl/mpfw_if.sv
hw/rtl/mpfw_ram.sv
hw/rtl/mpfw_byte_update.sv
hw/rtl/mono_page_framebuffer_writer.sv
hw/rtl/mpfw_checker.sv
verif/mpfw_byte_checker.sv
verif/mono_page_framebuffer_writer_test.sv
